### rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the list engine. All checks are clocked on
// i_clk and are switched off while i_rst_n is low.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ILE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("list engine check failed");

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ILE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("list engine check failed");

`endif

### rtl/ile_pkg.sv
// ============================================================================
// ile_pkg
// Types and fixed port widths shared by the list engine and its cells.
// ============================================================================
package ile_pkg;

    localparam int unsigned OP_BITS     = 3;
    localparam int unsigned INDEX_BITS  = 4;
    localparam int unsigned VALUE_BITS  = 32;
    localparam int unsigned STATUS_BITS = 2;
    localparam int unsigned COUNT_BITS  = 5;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD_BACK     = 3'd0,
        OP_ADD_FRONT    = 3'd1,
        OP_REMOVE_BACK  = 3'd2,
        OP_REMOVE_FRONT = 3'd3,
        OP_REMOVE_AT    = 3'd4,
        OP_GET          = 3'd5,
        OP_REPLACE      = 3'd6
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NULL  = 2'd3
    } t_status;

    // What one entry cell does at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_UP   = 2'd2,
        CELL_DOWN = 2'd3
    } t_cell_op;

endpackage

### rtl/ile_cell.sv
// ============================================================================
// ile_cell
// One entry slot of the list. It holds its word, loads a new word, or takes
// the word of the slot below (shift up) or above (shift down).
// ============================================================================
module ile_cell #(
    parameter int unsigned WIDTH = 32
) (
    input  logic              i_clk,
    input  ile_pkg::t_cell_op i_op,
    input  logic [WIDTH-1:0]  i_new,
    input  logic [WIDTH-1:0]  i_from_below,
    input  logic [WIDTH-1:0]  i_from_above,
    output logic [WIDTH-1:0]  o_data
);
    import ile_pkg::*;

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_LOAD: n_data = i_new;
            CELL_UP:   n_data = i_from_below;
            CELL_DOWN: n_data = i_from_above;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### rtl/indexed_list_engine.sv
// ============================================================================
// indexed_list_engine
// Bounded ordered list of words with deque and indexed operations.
// ============================================================================
// The list lives in a row of CAPACITY entry cells, slot 0 being the front.
// Every beat on the input channel carries one operation: add at the back,
// add at the front, remove from the back, remove from the front, remove at
// an index, get at an index, or replace at an index. Each accepted beat
// yields exactly one result beat carrying the removed, read or replaced-out
// word (zero when there is none), a status code and the entry count after
// the operation. All cells shift toward their neighbors in parallel on the
// accepting edge, and the result is registered in the output stage, so a
// new beat is taken every cycle as long as the output side keeps up. The
// input is ready whenever the output stage is empty or is being drained in
// the same cycle. Zero words are refused as null, adds to a full list
// report full, and removes or index accesses beyond the current count
// report a range error without touching the list. Entry storage needs no
// clearing after reset; only the count and the output valid flag are reset.
// ============================================================================
module indexed_list_engine #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ile_pkg::OP_BITS-1:0]     i_op,
    input  logic [ile_pkg::INDEX_BITS-1:0]  i_index,
    input  logic [ile_pkg::VALUE_BITS-1:0]  i_value,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ile_pkg::VALUE_BITS-1:0]  o_value_out,
    output logic [ile_pkg::STATUS_BITS-1:0] o_status,
    output logic [ile_pkg::COUNT_BITS-1:0]  o_count
);
    import ile_pkg::*;

    // Stored word width: the input port is only VALUE_BITS wide.
    localparam int unsigned ENTRY_BITS = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
    localparam int unsigned CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_BITS   = $clog2(CAPACITY);
    // Compare width wide enough for both the count and the input index.
    localparam int unsigned CW         = CNT_BITS + INDEX_BITS;

    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    logic                  r_out_valid;
    logic [ENTRY_BITS-1:0] r_value_out;
    t_status               r_status;

    logic                  w_fire;
    logic [ENTRY_BITS-1:0] w_value;
    logic                  w_null;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_idx_ok;
    logic [CW-1:0]         w_cnt;
    logic [CW-1:0]         w_idx;
    logic [CW-1:0]         w_pos;
    t_status               w_status;
    logic                  w_do_back;
    logic                  w_do_front;
    logic                  w_do_remove;
    logic                  w_do_replace;
    logic                  w_read;
    logic [ENTRY_BITS-1:0] w_read_data;

    logic [ENTRY_BITS-1:0] w_cell_q  [CAPACITY];
    t_cell_op              w_cell_op [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    assign w_value  = i_value[ENTRY_BITS-1:0];
    assign w_null   = (w_value == '0);
    assign w_cnt    = CW'(r_count);
    assign w_idx    = CW'(i_index);
    assign w_full   = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_idx_ok = (w_idx < w_cnt);

    // Operation decode: status, the position touched, and which kind of
    // cell movement the operation commits.
    always_comb begin
        w_status     = ST_OK;
        w_pos        = w_idx;
        w_do_back    = 1'b0;
        w_do_front   = 1'b0;
        w_do_remove  = 1'b0;
        w_do_replace = 1'b0;
        w_read       = 1'b0;
        case (t_op'(i_op))
            OP_ADD_BACK, OP_ADD_FRONT: begin
                if (w_null) begin
                    w_status = ST_NULL;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else if (t_op'(i_op) == OP_ADD_BACK) begin
                    w_do_back = 1'b1;
                end else begin
                    w_do_front = 1'b1;
                end
            end
            OP_REMOVE_BACK: begin
                w_pos = w_cnt - CW'(1);
                if (w_empty) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_remove = 1'b1;
                    w_read      = 1'b1;
                end
            end
            OP_REMOVE_FRONT: begin
                w_pos = '0;
                if (w_empty) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_remove = 1'b1;
                    w_read      = 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (!w_idx_ok) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_remove = 1'b1;
                    w_read      = 1'b1;
                end
            end
            OP_GET: begin
                if (!w_idx_ok) begin
                    w_status = ST_RANGE;
                end else begin
                    w_read = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (w_null) begin
                    w_status = ST_NULL;
                end else if (!w_idx_ok) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_replace = 1'b1;
                    w_read       = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    // The old word leaves through a single read port at the touched slot.
    assign w_read_data = w_read ? w_cell_q[w_pos[IDX_BITS-1:0]] : '0;

    // Per-cell movement. A remove shifts every slot at or above the removed
    // position down by one; slots beyond the count carry don't-care words.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_cell_op[k] = CELL_HOLD;
            if (w_fire) begin
                if (w_do_back && (CW'(k) == w_cnt)) begin
                    w_cell_op[k] = CELL_LOAD;
                end else if (w_do_front && (k == 0)) begin
                    w_cell_op[k] = CELL_LOAD;
                end else if (w_do_front && (CW'(k) <= w_cnt)) begin
                    w_cell_op[k] = CELL_UP;
                end else if (w_do_remove && (CW'(k) >= w_pos)) begin
                    w_cell_op[k] = CELL_DOWN;
                end else if (w_do_replace && (CW'(k) == w_pos)) begin
                    w_cell_op[k] = CELL_LOAD;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_BITS-1:0] w_below;
        logic [ENTRY_BITS-1:0] w_above;

        if (g == 0) begin : g_first
            assign w_below = w_value;
        end else begin : g_mid_lo
            assign w_below = w_cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_above = '0;
        end else begin : g_mid_hi
            assign w_above = w_cell_q[g+1];
        end

        ile_cell #(
            .WIDTH (ENTRY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_cell_op[g]),
            .i_new        (w_value),
            .i_from_below (w_below),
            .i_from_above (w_above),
            .o_data       (w_cell_q[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_fire) begin
            if (w_do_back || w_do_front) begin
                n_count = r_count + CNT_BITS'(1);
            end else if (w_do_remove) begin
                n_count = r_count - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the count output follows r_count, which changes only
    // on the same edge that loads a new result.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_value_out <= w_read_data;
            r_status    <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = VALUE_BITS'(r_value_out);
    assign o_status    = r_status;
    assign o_count     = COUNT_BITS'(r_count);

    `include "assert_macros.svh"

    // The list never holds more entries than its capacity.
    `ILE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_BITS'(CAPACITY))
    // A successful add grows the list by exactly one entry.
    `ILE_ASSERT_NEXT(a_add_grows, w_fire && (w_do_back || w_do_front), r_count == CNT_BITS'($past(r_count) + 1'b1))
    // Without an accepted beat the entry count does not move.
    `ILE_ASSERT_NEXT(a_count_idle, !w_fire, $stable(r_count))
    // Any error status comes with a zero word.
    `ILE_ASSERT_NOW(a_err_zero, r_out_valid && (r_status != ST_OK), r_value_out == '0)

endmodule
